>>> rtl/ldea_pkg.sv
package ldea_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LFB       = 24;
    localparam int LOG_W     = 6 + LFB;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] ADAPT_INIT = 32'(((64'd18 << FRAC_BITS) + 64'd50) / 64'd100);

    localparam logic [2:0] REG_MIN_LUM  = 3'd0;
    localparam logic [2:0] REG_MAX_LUM  = 3'd1;
    localparam logic [2:0] REG_BRIGHTEN = 3'd2;
    localparam logic [2:0] REG_DARKEN   = 3'd3;
    localparam logic [2:0] REG_ENABLE   = 3'd4;

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_LOG_INIT = 5'd2;
    localparam logic [4:0] OP_SQ       = 5'd3;
    localparam logic [4:0] OP_LOG_STO  = 5'd4;
    localparam logic [4:0] OP_RATE     = 5'd5;
    localparam logic [4:0] OP_W        = 5'd6;
    localparam logic [4:0] OP_P_INIT   = 5'd7;
    localparam logic [4:0] OP_P_MUL    = 5'd8;
    localparam logic [4:0] OP_DIV      = 5'd9;
    localparam logic [4:0] OP_P_ACC    = 5'd10;
    localparam logic [4:0] OP_E        = 5'd11;
    localparam logic [4:0] OP_A        = 5'd12;
    localparam logic [4:0] OP_STEP     = 5'd13;
    localparam logic [4:0] OP_NL       = 5'd14;
    localparam logic [4:0] OP_EXP      = 5'd15;
    localparam logic [4:0] OP_KEEP     = 5'd16;
    localparam logic [4:0] OP_FIN      = 5'd17;
    localparam logic [4:0] OP_FIN_D    = 5'd18;

    typedef struct packed {
        logic [31:0] min_lum;
        logic [31:0] max_lum;
        logic [15:0] brighten;
        logic [15:0] darken;
        logic        enable;
    } cfg_t;

    typedef struct packed {
        logic [4:0] op;
        logic       sel;
        logic [3:0] k;
    } cmd_t;

    typedef struct packed {
        logic direct;
        logic z_big;
        logic f_zero;
        logic a_zero;
    } sts_t;

    function automatic logic [31:0] clamp_lum(logic [31:0] x, logic [31:0] lo,
                                              logic [31:0] hi);
        logic [31:0] y;
        y = (x < lo) ? lo : x;
        return (y > hi) ? hi : y;
    endfunction

endpackage

>>> rtl/ldea_dp.sv
module ldea_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  ldea_pkg::cmd_t cmd,
    input  ldea_pkg::cfg_t cfg,
    input  logic           mode,
    input  logic [31:0]    luminance,
    input  logic [23:0]    frame_time,
    output ldea_pkg::sts_t sts,
    output logic [31:0]    adapted_luminance,
    output logic           history_valid
);
    import ldea_pkg::*;

    logic [31:0]             adapt_reg, adapt_next;
    logic                    hist_reg, hist_next;
    logic [31:0]             tgt_reg, tgt_next;
    logic [31:0]             cur_reg, cur_next;
    logic [23:0]             dt_reg, dt_next;
    logic [31:0]             m_reg, m_next;
    logic [LFB-1:0]          frac_reg, frac_next;
    logic signed [5:0]       lint_reg, lint_next;
    logic signed [LOG_W-1:0] cl_reg, cl_next;
    logic signed [LOG_W-1:0] tl_reg, tl_next;
    logic [39:0]             z_reg, z_next;
    logic [29:0]             w_reg, w_next;
    logic [29:0]             y_reg, y_next;
    logic [30:0]             term_reg, term_next;
    logic [31:0]             sum_reg, sum_next;
    logic [31:0]             dq_reg, dq_next;
    logic [3:0]              rem_reg, rem_next;
    logic [30:0]             e_reg, e_next;
    logic [30:0]             a_reg, a_next;
    logic [30:0]             step_reg, step_next;
    logic                    dneg_reg, dneg_next;
    logic signed [LOG_W-1:0] nl_reg, nl_next;
    logic [31:0]             out_reg, out_next;

    logic [31:0]             log_x;
    logic [4:0]              msb;
    logic [63:0]             sq;
    logic [15:0]             rate;
    logic [59:0]             w_prod;
    logic [5:0]              n_w;
    logic [24:0]             p_src;
    logic [54:0]             y_prod;
    logic [60:0]             t_prod;
    logic [4:0]              r5;
    logic [3:0]              rem_t;
    logic [31:0]             dq_t;
    logic signed [LOG_W:0]   d;
    logic [30:0]             mag;
    logic [61:0]             s_prod;
    logic signed [LOG_W:0]   nl_w;
    logic signed [7:0]       sh;
    logic [7:0]              nsh;
    logic [63:0]             shl;
    logic [6:0]              n_w1;

    assign sts.direct = mode | ~hist_reg | ~cfg.enable;
    assign sts.z_big  = (z_reg[39:29] != 11'd0);
    assign sts.f_zero = (w_reg[LFB-1:0] == '0);
    assign sts.a_zero = (a_reg == 31'd0);
    assign adapted_luminance = out_reg;
    assign history_valid     = hist_reg;

    always_comb
    begin
        log_x = cmd.sel ? tgt_reg : cur_reg;
        if (log_x == 32'd0)
        begin
            log_x = 32'd1;
        end
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (log_x[i])
            begin
                msb = 5'(i);
            end
        end
        sq     = {32'd0, m_reg} * {32'd0, m_reg};
        rate   = (tl_reg > cl_reg) ? cfg.brighten : cfg.darken;
        w_prod = z_reg[28:0] * LOG2E_Q30;
        n_w    = w_reg[29:24];
        n_w1   = {1'b0, n_w} + 7'd1;
        p_src  = cmd.sel ? {1'b0, nl_reg[LFB-1:0]} : (25'h100_0000 - {1'b0, w_reg[LFB-1:0]});
        y_prod = p_src * LN2_Q30;
        t_prod = term_reg * y_reg;
        d      = {cl_reg[LOG_W-1], cl_reg};
        d      = {tl_reg[LOG_W-1], tl_reg} - d;
        mag    = d[LOG_W] ? 31'(-d) : 31'(d);
        s_prod = mag * a_reg;
        nl_w   = dneg_reg ? ({cl_reg[LOG_W-1], cl_reg} - $signed({1'b0, step_reg[LOG_W-1:0]}))
                          : ({cl_reg[LOG_W-1], cl_reg} + $signed({1'b0, step_reg[LOG_W-1:0]}));
        sh     = $signed({{2{nl_reg[LOG_W-1]}}, nl_reg[LOG_W-1:LFB]}) + 8'(FRAC_BITS) - 8'sd30;
        nsh    = 8'(-sh);
        shl    = {32'd0, sum_reg} << sh[4:0];

        rem_t = rem_reg;
        dq_t  = dq_reg;
        for (int j = 0; j < 4; j++)
        begin
            r5 = {rem_t, dq_t[31]};
            if (r5 >= {1'b0, cmd.k})
            begin
                rem_t = 4'(r5 - {1'b0, cmd.k});
                dq_t  = {dq_t[30:0], 1'b1};
            end
            else
            begin
                rem_t = r5[3:0];
                dq_t  = {dq_t[30:0], 1'b0};
            end
        end

        adapt_next = adapt_reg;
        hist_next  = hist_reg;
        tgt_next   = tgt_reg;
        cur_next   = cur_reg;
        dt_next    = dt_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        lint_next  = lint_reg;
        cl_next    = cl_reg;
        tl_next    = tl_reg;
        z_next     = z_reg;
        w_next     = w_reg;
        y_next     = y_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        e_next     = e_reg;
        a_next     = a_reg;
        step_next  = step_reg;
        dneg_next  = dneg_reg;
        nl_next    = nl_reg;
        out_next   = out_reg;

        unique case (cmd.op)
            OP_LOAD:
            begin
                tgt_next = clamp_lum(luminance, cfg.min_lum, cfg.max_lum);
                cur_next = clamp_lum(adapt_reg, cfg.min_lum, cfg.max_lum);
                dt_next  = frame_time;
            end
            OP_LOG_INIT:
            begin
                m_next    = log_x << (5'd31 - msb);
                lint_next = $signed({1'b0, msb}) - 6'(FRAC_BITS);
                frac_next = '0;
            end
            OP_SQ:
            begin
                if (sq[63])
                begin
                    m_next = sq[63:32];
                end
                else
                begin
                    m_next = sq[62:31];
                end
                frac_next = {frac_reg[LFB-2:0], sq[63]};
            end
            OP_LOG_STO:
            begin
                if (cmd.sel)
                begin
                    tl_next = {lint_reg, frac_reg};
                end
                else
                begin
                    cl_next = {lint_reg, frac_reg};
                end
            end
            OP_RATE:
            begin
                z_next = rate * dt_reg;
            end
            OP_W:
            begin
                w_next = w_prod[59:30];
            end
            OP_P_INIT:
            begin
                y_next    = y_prod[53:24];
                term_next = Q30_ONE;
                sum_next  = {1'b0, Q30_ONE};
            end
            OP_P_MUL:
            begin
                dq_next  = {1'b0, t_prod[60:30]};
                rem_next = 4'd0;
            end
            OP_DIV:
            begin
                dq_next  = dq_t;
                rem_next = rem_t;
            end
            OP_P_ACC:
            begin
                term_next = dq_reg[30:0];
                sum_next  = sum_reg + dq_reg;
            end
            OP_E:
            begin
                if (sts.f_zero)
                begin
                    e_next = (n_w >= 6'd63) ? 31'd0 : (Q30_ONE >> n_w);
                end
                else
                begin
                    e_next = (n_w1 >= 7'd63) ? 31'd0 : 31'(sum_reg >> n_w1);
                end
            end
            OP_A:
            begin
                a_next = sts.z_big ? Q30_ONE : (Q30_ONE - e_reg);
            end
            OP_STEP:
            begin
                step_next = 31'(s_prod[61:30]);
                dneg_next = d[LOG_W];
            end
            OP_NL:
            begin
                nl_next = nl_w[LOG_W-1:0];
            end
            OP_EXP:
            begin
                if (!sh[7])
                begin
                    if (sh >= 8'sd32 || shl[63:32] != 32'd0)
                    begin
                        adapt_next = 32'hFFFF_FFFF;
                    end
                    else
                    begin
                        adapt_next = shl[31:0];
                    end
                end
                else if (nsh >= 8'd32)
                begin
                    adapt_next = 32'd0;
                end
                else
                begin
                    adapt_next = sum_reg >> nsh[4:0];
                end
            end
            OP_KEEP:
            begin
                adapt_next = cur_reg;
            end
            OP_FIN:
            begin
                out_next  = clamp_lum(adapt_reg, cfg.min_lum, cfg.max_lum);
                hist_next = 1'b1;
            end
            OP_FIN_D:
            begin
                adapt_next = tgt_reg;
                out_next   = tgt_reg;
                hist_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_reg <= ADAPT_INIT;
            hist_reg  <= 1'b0;
        end
        else
        begin
            adapt_reg <= adapt_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg  <= tgt_next;
        cur_reg  <= cur_next;
        dt_reg   <= dt_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        lint_reg <= lint_next;
        cl_reg   <= cl_next;
        tl_reg   <= tl_next;
        z_reg    <= z_next;
        w_reg    <= w_next;
        y_reg    <= y_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        e_reg    <= e_next;
        a_reg    <= a_next;
        step_reg <= step_next;
        dneg_reg <= dneg_next;
        nl_reg   <= nl_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/ldea_ctrl.sv
module ldea_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  ldea_pkg::sts_t sts,
    output ldea_pkg::cmd_t cmd
);
    import ldea_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOGI  = 5'd1;
    localparam logic [4:0] ST_SQ    = 5'd2;
    localparam logic [4:0] ST_LOGS  = 5'd3;
    localparam logic [4:0] ST_RATE  = 5'd4;
    localparam logic [4:0] ST_W     = 5'd5;
    localparam logic [4:0] ST_WCHK  = 5'd6;
    localparam logic [4:0] ST_PINIT = 5'd7;
    localparam logic [4:0] ST_PMUL  = 5'd8;
    localparam logic [4:0] ST_PDIV  = 5'd9;
    localparam logic [4:0] ST_PACC  = 5'd10;
    localparam logic [4:0] ST_E     = 5'd11;
    localparam logic [4:0] ST_A     = 5'd12;
    localparam logic [4:0] ST_ACHK  = 5'd13;
    localparam logic [4:0] ST_STEP  = 5'd14;
    localparam logic [4:0] ST_NL    = 5'd15;
    localparam logic [4:0] ST_EXP   = 5'd16;
    localparam logic [4:0] ST_KEEP  = 5'd17;
    localparam logic [4:0] ST_FIN   = 5'd18;
    localparam logic [4:0] ST_FIN_D = 5'd19;

    localparam logic [4:0] SQ_LAST  = 5'(LFB - 1);
    localparam logic [3:0] K_LAST   = 4'd12;
    localparam logic [2:0] DIV_LAST = 3'd7;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] k_reg, k_next;
    logic [2:0] dcnt_reg, dcnt_next;
    logic       sel_reg, sel_next;
    logic       pass_reg, pass_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;
    assign out_free  = ~(ov_reg & out_stall);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        dcnt_next  = dcnt_reg;
        sel_next   = sel_reg;
        pass_next  = pass_reg;
        ov_next    = ov_reg & out_stall;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        cmd.k      = k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    sel_next   = 1'b0;
                    state_next = sts.direct ? ST_FIN_D : ST_LOGI;
                end
            end
            ST_LOGI:
            begin
                cmd.op     = OP_LOG_INIT;
                cnt_next   = 5'd0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op   = OP_SQ;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = ST_LOGS;
                end
            end
            ST_LOGS:
            begin
                cmd.op = OP_LOG_STO;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_LOGI;
                end
                else
                begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = ST_W;
            end
            ST_W:
            begin
                cmd.op     = OP_W;
                state_next = ST_WCHK;
            end
            ST_WCHK:
            begin
                pass_next = 1'b0;
                if (sts.z_big)
                begin
                    state_next = ST_A;
                end
                else if (sts.f_zero)
                begin
                    state_next = ST_E;
                end
                else
                begin
                    state_next = ST_PINIT;
                end
            end
            ST_PINIT:
            begin
                cmd.op     = OP_P_INIT;
                cmd.sel    = pass_reg;
                k_next     = 4'd1;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.op     = OP_P_MUL;
                dcnt_next  = 3'd0;
                state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                cmd.op    = OP_DIV;
                dcnt_next = dcnt_reg + 3'd1;
                if (dcnt_reg == DIV_LAST)
                begin
                    state_next = ST_PACC;
                end
            end
            ST_PACC:
            begin
                cmd.op = OP_P_ACC;
                if (k_reg == K_LAST)
                begin
                    state_next = pass_reg ? ST_EXP : ST_E;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_PMUL;
                end
            end
            ST_E:
            begin
                cmd.op     = OP_E;
                state_next = ST_A;
            end
            ST_A:
            begin
                cmd.op     = OP_A;
                state_next = ST_ACHK;
            end
            ST_ACHK:
            begin
                state_next = sts.a_zero ? ST_KEEP : ST_STEP;
            end
            ST_STEP:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_NL;
            end
            ST_NL:
            begin
                cmd.op     = OP_NL;
                pass_next  = 1'b1;
                state_next = ST_PINIT;
            end
            ST_EXP:
            begin
                cmd.op     = OP_EXP;
                state_next = ST_FIN;
            end
            ST_KEEP:
            begin
                cmd.op     = OP_KEEP;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_FIN;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_D:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_FIN_D;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            k_reg     <= 4'd1;
            dcnt_reg  <= 3'd0;
            sel_reg   <= 1'b0;
            pass_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            dcnt_reg  <= dcnt_next;
            sel_reg   <= sel_next;
            pass_reg  <= pass_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

>>> rtl/log_domain_exposure_adaptation_unit.sv
// Temporal exposure adaptation: each item carries a metered luminance (Q16.16) and a frame
// time (Q8.16 seconds) and yields one item with the clamped adapted luminance. A prime item,
// an item with no history, or any item with adaptation disabled adopts the clamped value and
// skips the log-domain path. A smoothing update is run by one shared sequencer: two
// 24-step log2 squaring loops and up to two 12-term exp2 series, each term divided
// by a 4-bit-per-cycle divider. Items are taken one at a time, and the next item may enter
// while the previous result is still held on the output.
module log_domain_exposure_adaptation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] luminance,
    input  logic [23:0] frame_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] adapted_luminance,
    output logic        history_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ldea_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_LUM:  cfg_next.min_lum  = cfg_data;
                REG_MAX_LUM:  cfg_next.max_lum  = cfg_data;
                REG_BRIGHTEN: cfg_next.brighten = cfg_data[15:0];
                REG_DARKEN:   cfg_next.darken   = cfg_data[15:0];
                REG_ENABLE:   cfg_next.enable   = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_lum  <= 32'd66;
            cfg_reg.max_lum  <= 32'd4194304;
            cfg_reg.brighten <= 16'd768;
            cfg_reg.darken   <= 16'd256;
            cfg_reg.enable   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ldea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ldea_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg_reg),
        .mode              (mode),
        .luminance         (luminance),
        .frame_time        (frame_time),
        .sts               (sts),
        .adapted_luminance (adapted_luminance),
        .history_valid     (history_valid)
    );

endmodule

>>> tb/log_domain_exposure_adaptation_unit_test.sv
module log_domain_exposure_adaptation_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ldea_pkg::*;

    localparam int STALL_LIMIT = 6000;
    localparam int SETTLE_CYCLES = 340;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic        mode;
        logic [31:0] lum;
        logic [23:0] dt;
    } frame_t;

    typedef struct {
        logic [31:0] lum;
        logic        hist;
    } exposure_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [31:0] luminance;
    logic [23:0] frame_time;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] adapted_luminance;
    logic        history_valid;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_t    pending_frames[$];
    exposure_t expected_exposure[$];

    logic [31:0] lum_lo, lum_hi, adapted_lum;
    logic [15:0] rate_up, rate_down;
    logic        smoothing_on, has_hist;

    int  error_count;
    int  frames_sent;
    int  results_seen;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    int  hold_count;
    bit  quiet;
    bit  hold_request;

    log_domain_exposure_adaptation_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .luminance(luminance),
        .frame_time(frame_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .adapted_luminance(adapted_luminance),
        .history_valid(history_valid),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [31:0] limit_lum(logic [31:0] x);
        logic [31:0] y;
        y = (x < lum_lo) ? lum_lo : x;
        return (y > lum_hi) ? lum_hi : y;
    endfunction

    function automatic longint log2_lum(logic [31:0] x);
        int msb;
        longint unsigned m;
        longint fr;
        fr = 0;
        if (x == 0)
        begin
            x = 1;
        end
        msb = 31;
        while (!x[msb])
        begin
            msb--;
        end
        m = 64'(x) << (31 - msb);
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                fr = fr | 1;
            end
        end
        return longint'(msb - 16) * (longint'(1) << 24) + fr;
    endfunction

    function automatic longint unsigned pow2_fraction(longint unsigned f);
        longint unsigned y, sum, term;
        y = (f * 64'd744261118) >> 24;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * y) >> 30) / longint'(k);
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [31:0] exp2_lum(longint v);
        longint one, n, sh;
        longint unsigned p, r;
        one = longint'(1) << 24;
        if (v >= 0)
        begin
            n = v / one;
        end
        else
        begin
            n = -((-v + one - 1) / one);
        end
        p = pow2_fraction(longint'(v - n * one));
        sh = n + 16 - 30;
        if (sh >= 0)
        begin
            if (sh >= 32)
            begin
                return 32'hFFFF_FFFF;
            end
            r = p << sh;
            return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        end
        if (-sh >= 63)
        begin
            return 32'd0;
        end
        r = p >> (-sh);
        return r[31:0];
    endfunction

    function automatic longint unsigned blend_weight(logic [15:0] rate, logic [23:0] dt);
        longint unsigned z, w, n, f, e;
        z = 64'(rate) * 64'(dt);
        if (z >= (64'd32 << 24))
        begin
            return 64'd1 << 30;
        end
        w = (z * 64'd1549082005) >> 30;
        n = w >> 24;
        f = w & 64'hFF_FFFF;
        if (f == 0)
        begin
            e = (n >= 63) ? 0 : ((64'd1 << 30) >> n);
        end
        else
        begin
            e = (n + 1 >= 63) ? 0 : (pow2_fraction((64'd1 << 24) - f) >> (n + 1));
        end
        return (64'd1 << 30) - e;
    endfunction

    function automatic exposure_t adapt_exposure(frame_t fr);
        exposure_t res;
        logic [31:0] target, cur;
        longint cl, tl, d, step;
        longint unsigned a, mag;
        target = limit_lum(fr.lum);
        if (fr.mode || !has_hist || !smoothing_on)
        begin
            adapted_lum = target;
            res.lum = target;
        end
        else
        begin
            cur = limit_lum(adapted_lum);
            cl = log2_lum(cur);
            tl = log2_lum(target);
            a = blend_weight((tl > cl) ? rate_up : rate_down, fr.dt);
            if (a == 0)
            begin
                adapted_lum = cur;
            end
            else
            begin
                d = tl - cl;
                mag = (d >= 0) ? d : -d;
                step = longint'((mag * a) >> 30);
                adapted_lum = exp2_lum((d >= 0) ? cl + step : cl - step);
            end
            res.lum = limit_lum(adapted_lum);
        end
        has_hist = 1'b1;
        res.hist = 1'b1;
        return res;
    endfunction

    always @(posedge clk)
    begin
        frame_t fr;
        logic   next_valid;
        next_valid = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                fr.mode = mode;
                fr.lum = luminance;
                fr.dt = frame_time;
                expected_exposure.push_back(adapt_exposure(fr));
                frames_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_frames.size() > 0)
                begin
                    fr = pending_frames.pop_front();
                    mode <= fr.mode;
                    luminance <= fr.lum;
                    frame_time <= fr.dt;
                    next_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                    begin
                        send_gap = $urandom_range(1, 9);
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        exposure_t exp_item;
        logic      next_stall;
        next_stall = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_exposure.size() == 0)
                begin
                    $display("%0t: unexpected item, actual lum=%h hist=%b", $time,
                             adapted_luminance, history_valid);
                    error_count++;
                end
                else
                begin
                    exp_item = expected_exposure.pop_front();
                    if (adapted_luminance !== exp_item.lum)
                    begin
                        $display("%0t: adapted_luminance expected %h actual %h", $time,
                                 exp_item.lum, adapted_luminance);
                        error_count++;
                    end
                    if (history_valid !== exp_item.hist)
                    begin
                        $display("%0t: history_valid expected %b actual %b", $time,
                                 exp_item.hist, history_valid);
                        error_count++;
                    end
                end
            end
            if (hold_request && hold_count == 0)
            begin
                hold_request = 1'b0;
                hold_count = HOLD_CYCLES;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                next_stall = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                next_stall = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 8);
                next_stall = 1'b1;
            end
        end
        out_stall <= next_stall;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || hold_count > 0)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles with no progress.", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_LUM:  lum_lo = val;
            REG_MAX_LUM:  lum_hi = val;
            REG_BRIGHTEN: rate_up = val[15:0];
            REG_DARKEN:   rate_down = val[15:0];
            REG_ENABLE:   smoothing_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [31:0] lo, logic [31:0] hi, logic [15:0] up,
                              logic [15:0] down, logic en);
        write_reg(REG_MIN_LUM, lo);
        write_reg(REG_MAX_LUM, hi);
        write_reg(REG_BRIGHTEN, 32'(up));
        write_reg(REG_DARKEN, 32'(down));
        write_reg(REG_ENABLE, 32'(en));
    endtask

    task automatic add_frame(logic m, logic [31:0] lum, logic [23:0] dt);
        frame_t fr;
        fr.mode = m;
        fr.lum = lum;
        fr.dt = dt;
        pending_frames.push_back(fr);
    endtask

    task automatic add_random_frames(int count);
        logic [31:0] lum;
        logic [23:0] dt;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: lum = $urandom;
                1: lum = $urandom >> $urandom_range(0, 31);
                default: lum = 32'h0001_0000 + $urandom_range(0, 32'h000F_FFFF)
                               - 32'h0000_8000;
            endcase
            case ($urandom_range(0, 4))
                0: dt = $urandom;
                1: dt = 24'd0;
                default: dt = $urandom_range(0, 8191);
            endcase
            add_frame($urandom_range(0, 9) == 0, lum, dt);
        end
    endtask

    task automatic drain;
        while (pending_frames.size() > 0 || expected_exposure.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        luminance = 32'd0;
        frame_time = 24'd0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_LUM;
        cfg_data = 32'd0;
        error_count = 0;
        frames_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_count = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        lum_lo = 32'd66;
        lum_hi = 32'd4194304;
        rate_up = 16'd768;
        rate_down = 16'd256;
        smoothing_on = 1'b1;
        adapted_lum = ADAPT_INIT;
        has_hist = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_frame(1'b0, 32'd0, 24'd100);
        add_frame(1'b0, 32'hFFFF_FFFF, 24'd0);
        add_frame(1'b0, 32'd11796, 24'd65536);
        add_frame(1'b0, 32'h0002_0000, 24'hFF_FFFF);
        add_frame(1'b0, 32'h0002_0000, 24'd3000);
        add_frame(1'b1, 32'h0001_2345, 24'hFF_FFFF);
        add_frame(1'b1, 32'd0, 24'd0);
        add_frame(1'b0, 32'd1000, 24'd1);
        add_frame(1'b0, 32'h5555_5555, 24'hAA_AAAA);
        add_frame(1'b0, 32'hAAAA_AAAA, 24'h55_5555);
        add_random_frames(100);
        drain();

        set_limits(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b1);
        add_frame(1'b0, 32'd0, 24'd500);
        add_frame(1'b0, 32'hFFFF_FFFF, 24'd500);
        add_frame(1'b0, 32'd0, 24'd500);
        add_random_frames(100);
        hold_request = 1'b1;
        drain();

        set_limits(32'd5_000_000, 32'd1000, 16'd768, 16'd256, 1'b1);
        add_random_frames(60);
        drain();

        set_limits(32'd66, 32'd4194304, 16'd768, 16'd256, 1'b0);
        add_random_frames(80);
        drain();

        set_limits(32'd1, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b1);
        add_random_frames(120);
        drain();

        quiet = 1'b1;
        set_limits(32'd66, 32'd4194304, 16'd768, 16'd256, 1'b1);
        add_random_frames(120);
        drain();

        $display("Checked %0d of %0d frames over six limit and rate settings,", results_seen,
                 frames_sent);
        $display("including inverted limits, zero luminance and disabled smoothing.");
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/ldea_pkg.sv
rtl/ldea_dp.sv
rtl/ldea_ctrl.sv
rtl/log_domain_exposure_adaptation_unit.sv
tb/log_domain_exposure_adaptation_unit_test.sv
